[sv/bbrf_pkg.sv]
// shared types and constants for the burst byte ring fifo
// no dependencies; imported by bbrf_front, bbrf_back and the top level
package bbrf_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int CNT_W         = 7;
    localparam int DATA_W        = 8;
    localparam logic [CNT_W-1:0] ACC_MAX = 7'd64;

    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_GET = 1'b1;

    typedef struct packed {
        logic              is_get;
        logic [DATA_W-1:0] data;
        logic              burst_end;
        logic [CNT_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic byte_valid;
        logic [CNT_W-1:0] count;
        logic last;
        logic [CNT_W-1:0] free;
    } res_t;

endpackage

[sv/burst_byte_ring_fifo_core.sv]
// Burst byte ring fifo. Request beats enter through a queue-style port
// (push/full): req_type 0 is one byte of a put burst, burst_end marks its
// final byte; req_type 1 is a get of get_length bytes. Results leave through
// a queue-style port (empty/pop); the oldest result sits on the ports while
// empty is low.
// A marked put byte yields one acknowledgment with the accepted byte count;
// unmarked put bytes yield nothing. A get yields one beat per delivered byte,
// the final one flagged by last, or one empty beat if nothing is delivered.
// Every result carries the free space left in the ring.
// A request's first result passes the command queue, then the result
// register. While commands wait and the result register is free, put bytes
// run one per cycle and gets deliver one byte per cycle (single ring read port).
// A two-entry command queue sits between request decode and execution, and a
// result register lets the next command run while a result waits.
// When pop stays low, the result register holds and execution stops at the
// next beat that needs it; full rises once the command queue fills.
// Reset clears the counters and both queues; the ring contents are not
// cleared and are only read after being written.
// depends on bbrf_pkg, bbrf_front, bbrf_back
module burst_byte_ring_fifo_core
    import bbrf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              req_type,
    input  logic [DATA_W-1:0] data_in,
    input  logic              burst_end,
    input  logic [CNT_W-1:0]  get_length,
    output logic              empty,
    input  logic              pop,
    output logic              kind,
    output logic [DATA_W-1:0] data_out,
    output logic              byte_valid,
    output logic [CNT_W-1:0]  transfer_count,
    output logic              last,
    output logic [CNT_W-1:0]  free_space
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic res_valid;
    res_t res;

    bbrf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .data_in    (data_in),
        .burst_end  (burst_end),
        .get_length (get_length),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    bbrf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_data  (data_out),
        .res_pop   (pop)
    );

    assign empty          = !res_valid;
    assign kind           = res.kind;
    assign byte_valid     = res.byte_valid;
    assign transfer_count = res.count;
    assign last           = res.last;
    assign free_space     = res.free;

endmodule

[sv/bbrf_front.sv]
// front end: accepts request beats, decodes them into commands and
// holds them in a two-entry queue for the back end; uses bbrf_pkg
module bbrf_front
    import bbrf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic             req_type,
    input  logic [DATA_W-1:0] data_in,
    input  logic             burst_end,
    input  logic [CNT_W-1:0] get_length,
    output logic             cmd_valid,
    output cmd_t             cmd,
    input  logic             cmd_pop
);

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;
    cmd_t       dec;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        dec.is_get    = (req_type == REQ_GET);
        dec.data      = data_in;
        dec.burst_end = burst_end;
        dec.len       = get_length;
    end

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[sv/bbrf_back.sv]
// back end: ring store, write and read counters, get sequencing and the
// result register; uses bbrf_pkg
module bbrf_back
    import bbrf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              cmd_pop,
    output logic              res_valid,
    output res_t              res,
    output logic [DATA_W-1:0] res_data,
    input  logic              res_pop
);

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0] wc_reg, wc_next;
    logic [CNT_W-1:0] rc_reg, rc_next;
    logic [CNT_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             ov_reg, ov_next;
    res_t             res_reg, res_next;
    logic [DATA_W-1:0] data_reg;

    logic [CNT_W-1:0] stored;
    logic [CNT_W-1:0] n_cur;
    logic [CNT_W-1:0] rc_inc;
    logic [CNT_W-1:0] k_inc;
    logic             out_free;
    logic             is_full;
    logic             wr_en;
    logic             rd_en;
    logic             emit;

    assign stored    = wc_reg - rc_reg;
    assign is_full   = (stored >= DEPTH_C);
    assign out_free  = !ov_reg || res_pop;
    assign rc_inc    = rc_reg + 7'd1;
    assign k_inc     = k_reg + 7'd1;
    assign n_cur     = (k_reg != 7'd0) ? n_reg :
                       ((cmd.len < stored) ? cmd.len : stored);
    assign res_valid = ov_reg;
    assign res       = res_reg;
    assign res_data  = data_reg;

    always_comb
    begin
        wc_next  = wc_reg;
        rc_next  = rc_reg;
        acc_next = acc_reg;
        k_next   = k_reg;
        n_next   = n_reg;
        ov_next  = ov_reg && !res_pop;
        res_next = res_reg;
        cmd_pop  = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        emit     = 1'b0;

        if (cmd_valid && !cmd.is_get && (!cmd.burst_end || out_free))
        begin
            cmd_pop = 1'b1;
            if (!is_full)
            begin
                wr_en   = 1'b1;
                wc_next = wc_reg + 7'd1;
                if (acc_reg < ACC_MAX)
                begin
                    acc_next = acc_reg + 7'd1;
                end
            end
            if (cmd.burst_end)
            begin
                emit                = 1'b1;
                res_next.kind       = KIND_ACK;
                res_next.byte_valid = 1'b0;
                res_next.count      = acc_next;
                res_next.last       = 1'b1;
                res_next.free       = DEPTH_C - (wc_next - rc_next);
                acc_next            = 7'd0;
            end
        end
        else if (cmd_valid && cmd.is_get && out_free)
        begin
            emit          = 1'b1;
            res_next.kind = KIND_GET;
            if (n_cur == 7'd0)
            begin
                cmd_pop = 1'b1;
                if (wc_reg == rc_reg)
                begin
                    wc_next = 7'd0;
                    rc_next = 7'd0;
                end
                res_next.byte_valid = 1'b0;
                res_next.count      = 7'd0;
                res_next.last       = 1'b1;
            end
            else
            begin
                rd_en   = 1'b1;
                rc_next = rc_inc;
                // ring drained: both counters restart at zero
                if (wc_reg == rc_inc)
                begin
                    wc_next = 7'd0;
                    rc_next = 7'd0;
                end
                n_next              = n_cur;
                res_next.byte_valid = 1'b1;
                res_next.count      = k_inc;
                res_next.last       = (k_inc == n_cur);
                if (k_inc == n_cur)
                begin
                    cmd_pop = 1'b1;
                    k_next  = 7'd0;
                end
                else
                begin
                    k_next = k_inc;
                end
            end
            res_next.free = DEPTH_C - (wc_next - rc_next);
        end

        if (emit)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wc_reg[SLOT_W-1:0]] <= cmd.data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rc_reg[SLOT_W-1:0]];
        end
        else if (emit)
        begin
            data_reg <= '0;
        end
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg  <= '0;
            rc_reg  <= '0;
            acc_reg <= '0;
            k_reg   <= '0;
            n_reg   <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            wc_reg  <= wc_next;
            rc_reg  <= rc_next;
            acc_reg <= acc_next;
            k_reg   <= k_next;
            n_reg   <= n_next;
            ov_reg  <= ov_next;
        end
    end

endmodule

[tb/bbrf_beat_checker.sv]
`timescale 1ns / 1ps
// checker for burst_byte_ring_fifo_core: watches the request and result queues,
// predicts the result beats of every accepted request and compares them in order
// depends on bbrf_pkg; instanced beside the block by burst_byte_ring_fifo_core_tb
module bbrf_beat_checker
    import bbrf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic              req_type,
    input  logic [DATA_W-1:0] data_in,
    input  logic              burst_end,
    input  logic [CNT_W-1:0]  get_length,
    input  logic              empty,
    input  logic              pop,
    input  logic              kind,
    input  logic [DATA_W-1:0] data_out,
    input  logic              byte_valid,
    input  logic [CNT_W-1:0]  transfer_count,
    input  logic              last,
    input  logic [CNT_W-1:0]  free_space,
    output int                fail_count,
    output int                pending
);

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] data;
        logic              byte_valid;
        logic [CNT_W-1:0]  count;
        logic              last;
        logic [CNT_W-1:0]  free;
    } beat_t;

    logic [DATA_W-1:0] ring_bytes [DEPTH];
    logic [CNT_W-1:0]  wr_ptr;
    logic [CNT_W-1:0]  rd_ptr;
    logic [CNT_W-1:0]  burst_bytes;
    beat_t             due_beats [$];
    int                errs;

    function automatic logic [CNT_W-1:0] fill_level();
        return wr_ptr - rd_ptr;
    endfunction

    function automatic logic [CNT_W-1:0] room_left();
        logic [CNT_W-1:0] lvl;
        lvl = fill_level();
        return (lvl >= DEPTH) ? '0 : CNT_W'(DEPTH) - lvl;
    endfunction

    task automatic show_beat(input string tag, input beat_t b);
        $display("  %s kind %0d data %02h valid %0d count %0d last %0d free %0d",
                 tag, b.kind, b.data, b.byte_valid, b.count, b.last, b.free);
    endtask

    // free space is taken after the state change that the beat reports
    task automatic queue_beat(input logic k, input logic [DATA_W-1:0] d, input logic v,
                              input logic [CNT_W-1:0] c, input logic l);
        beat_t b;
        b.kind       = k;
        b.data       = d;
        b.byte_valid = v;
        b.count      = c;
        b.last       = l;
        b.free       = room_left();
        due_beats.push_back(b);
    endtask

    task automatic predict_ring_beats(input logic rt, input logic [DATA_W-1:0] d,
                                      input logic e, input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0]  avail;
        logic [CNT_W-1:0]  n;
        logic [DATA_W-1:0] b;
        int                i;
        if (rt == REQ_PUT)
        begin
            if (fill_level() < DEPTH)
            begin
                ring_bytes[wr_ptr[SLOT_W-1:0]] = d;
                wr_ptr++;
                if (burst_bytes < ACC_MAX)
                    burst_bytes++;
            end
            if (e)
            begin
                queue_beat(KIND_ACK, '0, 1'b0, burst_bytes, 1'b1);
                burst_bytes = '0;
            end
        end
        else
        begin
            avail = fill_level();
            n     = (len < avail) ? len : avail;
            if (n == 0)
            begin
                if (wr_ptr == rd_ptr)
                begin
                    wr_ptr = '0;
                    rd_ptr = '0;
                end
                queue_beat(KIND_GET, '0, 1'b0, '0, 1'b1);
            end
            else
            begin
                for (i = 1; i <= n; i++)
                begin
                    b = ring_bytes[rd_ptr[SLOT_W-1:0]];
                    rd_ptr++;
                    // counters fold back to zero as soon as the ring runs dry
                    if (wr_ptr == rd_ptr)
                    begin
                        wr_ptr = '0;
                        rd_ptr = '0;
                    end
                    queue_beat(KIND_GET, b, 1'b1, CNT_W'(i), i == n);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beat_t seen;
        beat_t want;
        if (!rst_n)
        begin
            wr_ptr      = '0;
            rd_ptr      = '0;
            burst_bytes = '0;
            errs        = 0;
            due_beats.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (push && !full)
                predict_ring_beats(req_type, data_in, burst_end, get_length);
            if (pop && !empty)
            begin
                seen = {kind, data_out, byte_valid, transfer_count, last, free_space};
                if (due_beats.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                    begin
                        $display("%0t: result beat with nothing due", $realtime);
                        show_beat("actual  ", seen);
                    end
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (seen !== want)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $display("%0t: result beat differs", $realtime);
                            show_beat("expected", want);
                            show_beat("actual  ", seen);
                        end
                    end
                end
            end
            fail_count <= errs;
            pending    <= due_beats.size();
        end
    end

endmodule

[tb/burst_byte_ring_fifo_core_tb.sv]
`timescale 1ns / 1ps
// top of the burst_byte_ring_fifo_core testbench: clock, reset, request and pop
// stimulus, watchdog and verdict; depends on bbrf_pkg, bbrf_beat_checker and the block
module burst_byte_ring_fifo_core_tb;
    import bbrf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 20;
    localparam int ITEM_TARGET = 390;
    localparam int QUIET_FROM  = 340;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              req_type;
    logic [DATA_W-1:0] data_in;
    logic              burst_end;
    logic [CNT_W-1:0]  get_length;
    logic              empty;
    logic              pop;
    logic              kind;
    logic [DATA_W-1:0] data_out;
    logic              byte_valid;
    logic [CNT_W-1:0]  transfer_count;
    logic              last;
    logic [CNT_W-1:0]  free_space;
    int                fail_count;
    int                pending;

    int items_sent;
    int tx_odds;
    int rx_odds;
    bit quiet;
    bit long_hold;
    bit hold_done;
    int stall_cycles;

    burst_byte_ring_fifo_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .data_in        (data_in),
        .burst_end      (burst_end),
        .get_length     (get_length),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .data_out       (data_out),
        .byte_valid     (byte_valid),
        .transfer_count (transfer_count),
        .last           (last),
        .free_space     (free_space)
    );

    bbrf_beat_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .data_in        (data_in),
        .burst_end      (burst_end),
        .get_length     (get_length),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .data_out       (data_out),
        .byte_valid     (byte_valid),
        .transfer_count (transfer_count),
        .last           (last),
        .free_space     (free_space),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CNT_W-1:0] pick_len();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return 7'd64;
            2: return CNT_W'($urandom_range(33, 63));
            default: return CNT_W'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic maybe_gap();
        if (!quiet && tx_odds != 0 && $urandom_range(1, 16) <= tx_odds)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clk);
        end
    endtask

    task automatic send_item(input logic rt, input logic [DATA_W-1:0] d, input logic e,
                             input logic [CNT_W-1:0] len);
        maybe_gap();
        @(negedge clk);
        push       <= 1'b1;
        req_type   <= rt;
        data_in    <= d;
        burst_end  <= e;
        get_length <= len;
        do
            @(posedge clk);
        while (full);
        items_sent++;
    endtask

    task automatic get_req();
        send_item(REQ_GET, DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  pick_len());
    endtask

    // get_odds out of 16: chance of a get request slipping in between burst bytes
    task automatic put_burst(input int n, input bit mark, input int get_odds);
        int i;
        for (i = 0; i < n; i++)
        begin
            if (get_odds != 0 && $urandom_range(1, 16) <= get_odds)
                get_req();
            send_item(REQ_PUT, DATA_W'($urandom_range(0, 255)), mark && (i == n - 1),
                      CNT_W'($urandom_range(0, 64)));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // result side: random pop bursts, plus one long hold when asked
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                rx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (long_hold)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && rx_odds != 0 && $urandom_range(1, 16) <= rx_odds)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int i;
        rst_n      = 1'b0;
        push       = 1'b0;
        req_type   = REQ_PUT;
        data_in    = '0;
        burst_end  = 1'b0;
        get_length = '0;
        items_sent = 0;
        tx_odds    = 0;
        rx_odds    = 0;
        quiet      = 1'b0;
        long_hold  = 1'b0;
        hold_done  = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // get on an empty ring, then a zero-length get on a non-empty one
        send_item(REQ_GET, 8'h00, 1'b0, 7'd5);
        send_item(REQ_PUT, 8'h00, 1'b1, 7'd0);
        send_item(REQ_GET, 8'hFF, 1'b1, 7'd0);
        send_item(REQ_PUT, 8'hFF, 1'b0, 7'd64);
        send_item(REQ_PUT, 8'hA5, 1'b1, 7'd0);
        // asks for more than is stored
        send_item(REQ_GET, 8'h00, 1'b0, 7'd64);
        // get served in the middle of a burst
        send_item(REQ_PUT, 8'h5A, 1'b0, 7'd0);
        send_item(REQ_GET, 8'h00, 1'b0, 7'd1);
        send_item(REQ_PUT, 8'hC3, 1'b1, 7'd0);
        send_item(REQ_GET, 8'hFF, 1'b1, 7'd64);
        wait_drained();

        // accepted count past 64 saturates; the ring fills and drops bytes
        put_burst(64, 1'b0, 0);
        send_item(REQ_GET, 8'h00, 1'b0, 7'd16);
        put_burst(20, 1'b1, 0);
        send_item(REQ_GET, 8'h00, 1'b0, 7'd64);
        send_item(REQ_GET, 8'h00, 1'b0, 7'd64);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_FROM)
                quiet = 1'b1;
            tx_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (!hold_done && items_sent >= 250)
            begin
                // stall the result side so the command queue backs up
                long_hold = 1'b1;
                tx_odds   = 0;
                for (i = 0; i < 30; i++)
                begin
                    if ($urandom_range(0, 1))
                        send_item(REQ_GET, DATA_W'($urandom_range(0, 255)), 1'b0,
                                  CNT_W'($urandom_range(1, 3)));
                    else
                        send_item(REQ_PUT, DATA_W'($urandom_range(0, 255)), 1'b1, 7'd0);
                end
                wait_drained();
                hold_done = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: put_burst($urandom_range(1, 12), 1'b1, 0);
                4:          put_burst($urandom_range(40, 70), 1'b1, 2);
                5, 6, 7:    get_req();
                8:          put_burst($urandom_range(1, 8), 1'b1, 4);
                default:    send_item(1'($urandom_range(0, 1)),
                                      DATA_W'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)), pick_len());
            endcase
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[burst_byte_ring_fifo_core.f]
sv/bbrf_pkg.sv
sv/bbrf_front.sv
sv/bbrf_back.sv
sv/burst_byte_ring_fifo_core.sv
tb/bbrf_beat_checker.sv
tb/burst_byte_ring_fifo_core_tb.sv
